// ===== hdl/eftq_pkg.sv =====
// shared constants, codes and handshake structs for the eligibility filtered task queue
// used by the controller, the datapath, the top level and the port checker
`timescale 1ns / 1ps

package eftq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_N       = $clog2(QUEUE_DEPTH);
  localparam int PARKED_W    = 12;

  // operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ENQUEUE = 2'd1;
  localparam logic [1:0] OP_DEQUEUE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input item
    logic match;  // register the eligible-entry vector
    logic apply;  // update the cells and load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;  // result register empty or being taken this cycle
  } sts_t;

endpackage

// ===== hdl/eftq_ctrl.sv =====
// sequencing state machine for the eligibility filtered task queue
// depends on eftq_pkg for the command and status structs
`timescale 1ns / 1ps

module eftq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  eftq_pkg::sts_t sts_i,
  output eftq_pkg::cmd_t cmd_o
);
  import eftq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       apply_go;

  // an item may enter while idle or in the cycle the previous one retires
  assign apply_go   = (state_q == ST_APPLY) && sts_i.slot_free;
  assign in_ready_o = (state_q == ST_IDLE) || apply_go;
  assign accept     = in_valid_i && in_ready_o;

  // commands to the datapath
  assign cmd_o.load  = accept;
  assign cmd_o.match = (state_q == ST_MATCH);
  assign cmd_o.apply = apply_go;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_go) state_d = accept ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/eftq_dp.sv =====
// collapsing cell chain, occupancy counter and result register of the task queue
// depends on eftq_pkg for geometry, op codes and the command and status structs
`timescale 1ns / 1ps

module eftq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  eftq_pkg::cmd_t                  cmd_i,
  output eftq_pkg::sts_t                  sts_o,
  input  logic [1:0]                      op_i,
  input  logic                            task_kind_i,
  input  logic                            lot_full_i,
  input  logic [eftq_pkg::PARKED_W-1:0]   parked_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            accepted_o,
  output logic                            removed_kind_o,
  output logic [eftq_pkg::CNT_W-1:0]      entry_count_o
);
  import eftq_pkg::*;

  // captured item
  logic [1:0] op_q;
  logic       kind_q;
  logic       full_q;
  logic       pnz_q;

  // cells, oldest entry at index 0
  logic [QUEUE_DEPTH-1:0] cells_q, cells_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [QUEUE_DEPTH-1:0] match_q;

  // result register
  logic             out_valid_q;
  logic             acc_q, acc_d;
  logic             rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;

  logic [QUEUE_DEPTH-1:0] valid_v;
  logic [QUEUE_DEPTH-1:0] elig_v;
  logic [QUEUE_DEPTH-1:0] wr_v;
  logic [QUEUE_DEPTH-1:0] pre [LVL_N+1];
  logic [QUEUE_DEPTH-1:0] after_v;
  logic [QUEUE_DEPTH-1:0] first_v;
  logic                   found;

  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  // per-cell valid flag and write decode from the occupancy
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid_v[i] = (CNT_W'(i) < occ_q);
      wr_v[i]    = (CNT_W'(i) == occ_q);
    end
  end

  // eligibility per cell: exit needs parked cars, park needs a free lot
  assign elig_v = (cells_q & {QUEUE_DEPTH{pnz_q}}) | (~cells_q & {QUEUE_DEPTH{~full_q}});

  // prefix or over the registered match vector, log depth levels
  always_comb begin
    pre[0] = match_q;
    for (int l = 0; l < LVL_N; l++) begin
      pre[l+1] = pre[l] | (pre[l] << (1 << l));
    end
  end

  assign after_v = pre[LVL_N];
  assign first_v = after_v & ~(after_v << 1);
  assign found   = |match_q;

  // next cells, occupancy and result
  always_comb begin
    cells_d = cells_q;
    occ_d   = occ_q;
    acc_d   = 1'b0;
    rem_d   = 1'b0;
    case (op_q)
      OP_CLEAR: begin
        occ_d = '0;
      end
      OP_ENQUEUE: begin
        if (occ_q < CNT_W'(QUEUE_DEPTH)) begin
          cells_d = (cells_q & ~wr_v) | (wr_v & {QUEUE_DEPTH{kind_q}});
          occ_d   = occ_q + CNT_W'(1);
          acc_d   = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (found) begin
          // cells at and behind the removed one move up by one place
          cells_d = (cells_q & ~after_v) | ((cells_q >> 1) & after_v);
          occ_d   = occ_q - CNT_W'(1);
          acc_d   = 1'b1;
          rem_d   = |(first_v & cells_q);
        end
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  // payload registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      kind_q <= task_kind_i;
      full_q <= lot_full_i;
      pnz_q  <= |parked_count_i;
    end
    if (cmd_i.match) begin
      match_q <= valid_v & elig_v;
    end
    if (cmd_i.apply) begin
      cells_q <= cells_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      cnt_q   <= occ_d;
    end
  end

  // occupancy and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        occ_q <= occ_d;
      end
      if (cmd_i.apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign removed_kind_o = rem_q;
  assign entry_count_o  = cnt_q;

endmodule

// ===== hdl/eligibility_filtered_task_queue.sv =====
// Eligibility filtered task queue: an ordered queue of park/exit tasks with clear,
// enqueue and a dequeue that removes the oldest eligible entry and closes the gap.
//
// Channels: the input item (op_i, task_kind_i, lot_full_i, parked_count_i) is taken
// on in_valid_i && in_ready_o; one result item (accepted_o, removed_kind_o,
// entry_count_o) per input item is offered on out_valid_o and taken with out_ready_i.
// Path: the input item is registered first, then the eligible-entry vector of the cell
// chain is registered, then a prefix-or runs over it, the cells behind the hit shift up
// one place and the result register is loaded.
// Overlap: the next item is taken in the cycle the previous one is written to the
// result register.
// Reset: rst_ni (async, active low) empties the queue and drops any pending result;
// the cell contents themselves are not cleared and need no clearing pass.
// Stall: a waiting result is held stable; one more item can be taken and matched,
// then the block waits until the result register frees up.
// Depends on eftq_pkg, eftq_ctrl and eftq_dp.
`timescale 1ns / 1ps

module eligibility_filtered_task_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic                          task_kind_i,
  input  logic                          lot_full_i,
  input  logic [eftq_pkg::PARKED_W-1:0] parked_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic                          removed_kind_o,
  output logic [eftq_pkg::CNT_W-1:0]    entry_count_o
);
  import eftq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  eftq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // cell chain and result register
  eftq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .task_kind_i    (task_kind_i),
    .lot_full_i     (lot_full_i),
    .parked_count_i (parked_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .removed_kind_o (removed_kind_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

// ===== hdl/eftq_checker.sv =====
// port-level checks for the eligibility filtered task queue, bound to the top level
// depends on eftq_pkg for the queue depth
`timescale 1ns / 1ps

module eftq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          accepted_o,
  input logic                          removed_kind_o,
  input logic [eftq_pkg::CNT_W-1:0]    entry_count_o
);
  import eftq_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(entry_count_o))
    else $error("entry count changed while stalled");

  // the count never exceeds the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // a removed kind is only reported for a successful operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_kind_o |-> accepted_o)
    else $error("removed kind without acceptance");

  // an item is matched before the next one can enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken in back-to-back cycles");

endmodule

bind eligibility_filtered_task_queue eftq_checker u_eftq_checker (.*);

// ===== sim/tb_eligibility_filtered_task_queue.sv =====
// testbench for the eligibility filtered task queue: directed and random park/exit traffic
// checked against a queue model kept in the bench; depends on eftq_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_eligibility_filtered_task_queue;
  import eftq_pkg::*;

  // unused op code and task kinds
  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic       KIND_PARK = 1'b0;
  localparam logic       KIND_EXIT = 1'b1;

  typedef struct packed {
    logic             accepted;
    logic             removed_kind;
    logic [CNT_W-1:0] entry_count;
  } result_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [1:0]          op_i           = OP_CLEAR;
  logic                task_kind_i    = KIND_PARK;
  logic                lot_full_i     = 1'b0;
  logic [PARKED_W-1:0] parked_count_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                accepted_o;
  logic                removed_kind_o;
  logic [CNT_W-1:0]    entry_count_o;

  // queue contents as the bench sees them, oldest first
  logic    queued_kinds[$];
  result_t expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int checked_count  = 0;
  int sent_count     = 0;
  int drop_count     = 0;
  int miss_count     = 0;
  int park_removed   = 0;
  int exit_removed   = 0;
  int peak_entries   = 0;

  eligibility_filtered_task_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .task_kind_i    (task_kind_i),
    .lot_full_i     (lot_full_i),
    .parked_count_i (parked_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .removed_kind_o (removed_kind_o),
    .entry_count_o  (entry_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one item to the queue model and return the result it should give
  function automatic result_t predict_queue_result(logic [1:0] op, logic kind, logic full,
                                                   logic [PARKED_W-1:0] parked);
    result_t res;
    logic    ok;
    res = '0;
    case (op)
      OP_CLEAR: begin
        queued_kinds.delete();
      end
      OP_ENQUEUE: begin
        if (queued_kinds.size() < QUEUE_DEPTH) begin
          queued_kinds.insert(queued_kinds.size(), kind);
          res.accepted = 1'b1;
        end else begin
          drop_count++;
        end
      end
      OP_DEQUEUE: begin
        for (int i = 0; i < queued_kinds.size(); i++) begin
          ok = (queued_kinds[i] == KIND_EXIT) ? (parked != '0) : !full;
          if (ok) begin
            res.accepted     = 1'b1;
            res.removed_kind = queued_kinds[i];
            if (queued_kinds[i] == KIND_EXIT) exit_removed++;
            else park_removed++;
            queued_kinds.delete(i);
            break;
          end
        end
        if (!res.accepted) miss_count++;
      end
      default: begin
      end
    endcase
    res.entry_count = CNT_W'(queued_kinds.size());
    if (queued_kinds.size() > peak_entries) peak_entries = queued_kinds.size();
    return res;
  endfunction

  // present one item, hold it until taken, then record what it should produce
  task automatic send_item(logic [1:0] op, logic kind, logic full, logic [PARKED_W-1:0] parked);
    result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    task_kind_i    <= kind;
    lot_full_i     <= full;
    parked_count_i <= parked;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = predict_queue_result(op, kind, full, parked);
    expected_results.insert(expected_results.size(), want);
    sent_count++;
  endtask

  // parked count biased toward zero and the top value
  function automatic logic [PARKED_W-1:0] pick_parked();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return '0;
    if (roll < 35) return '1;
    return PARKED_W'($urandom_range(4095, 1));
  endfunction

  task automatic enqueue_kind(logic kind);
    send_item(OP_ENQUEUE, kind, 1'($urandom), PARKED_W'($urandom));
  endtask

  task automatic dequeue_with(logic full, logic [PARKED_W-1:0] parked);
    send_item(OP_DEQUEUE, 1'($urandom), full, parked);
  endtask

  task automatic send_plain(logic [1:0] op);
    send_item(op, 1'($urandom), 1'($urandom), PARKED_W'($urandom));
  endtask

  // receiver stalls per cycle at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every taken result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: accepted %0b kind %0b count %0d",
                 $time, accepted_o, removed_kind_o, entry_count_o);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (accepted_o !== want.accepted) begin
          error_count++;
          $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, accepted_o);
        end
        if (removed_kind_o !== want.removed_kind) begin
          error_count++;
          $display("%0t: removed_kind expected %0b actual %0b",
                   $time, want.removed_kind, removed_kind_o);
        end
        if (entry_count_o !== want.entry_count) begin
          error_count++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, entry_count_o);
        end
      end
    end
  end

  // empty queue: dequeue, unused op and clear all leave nothing behind
  task automatic test_empty_queue();
    dequeue_with(1'b0, '1);
    send_plain(OP_NONE);
    send_plain(OP_CLEAR);
    dequeue_with(1'b1, '1);
  endtask

  // eligibility rules: skip ineligible heads, remove from the middle and the tail
  task automatic test_eligibility();
    enqueue_kind(KIND_EXIT);
    enqueue_kind(KIND_PARK);
    enqueue_kind(KIND_EXIT);
    enqueue_kind(KIND_PARK);
    dequeue_with(1'b1, '0);
    dequeue_with(1'b0, '0);
    dequeue_with(1'b0, '0);
    dequeue_with(1'b1, '0);
    dequeue_with(1'b1, '1);
    send_plain(OP_NONE);
    dequeue_with(1'b1, 12'd1);
    enqueue_kind(KIND_PARK);
    dequeue_with(1'b1, '1);
    dequeue_with(1'b0, '0);
  endtask

  // fill to capacity, drop on full, free one place, refill, then clear
  task automatic test_capacity();
    for (int i = 0; i < QUEUE_DEPTH; i++) enqueue_kind(1'($urandom));
    enqueue_kind(KIND_PARK);
    enqueue_kind(KIND_EXIT);
    send_plain(OP_NONE);
    dequeue_with(1'b0, '1);
    enqueue_kind(KIND_EXIT);
    enqueue_kind(KIND_PARK);
    dequeue_with(1'b1, '0);
    send_plain(OP_CLEAR);
    dequeue_with(1'b0, '1);
  endtask

  // random traffic in fill, drain and churn stretches so the queue sweeps its depth
  task automatic test_random_traffic(int count);
    int run_left;
    int enq_pct;
    int roll;
    run_left = 0;
    enq_pct  = 50;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0:       enq_pct = 75;
          1:       enq_pct = 25;
          default: enq_pct = 50;
        endcase
      end
      run_left--;
      roll = $urandom_range(199);
      if (roll < 2) send_plain(OP_CLEAR);
      else if (roll < 4) send_plain(OP_NONE);
      else if ($urandom_range(99) < enq_pct) enqueue_kind(1'($urandom));
      else dequeue_with(1'($urandom), pick_parked());
    end
  endtask

  // wait for every outstanding result, then idle before the report
  task automatic drain_results();
    int waited;
    waited = 0;
    while (expected_results.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 10;
    recv_stall_pct = 82;
    test_empty_queue();
    test_eligibility();
    test_capacity();
    test_random_traffic(320);

    send_idle_pct  = 82;
    recv_stall_pct = 10;
    test_random_traffic(320);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(320);
    in_valid_i <= 1'b0;

    drain_results();
    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("ran %0d items, checked %0d results; %0d park and %0d exit removals",
             sent_count, checked_count, park_removed, exit_removed);
    $display("%0d dequeue misses, %0d enqueues dropped on full, peak occupancy %0d",
             miss_count, drop_count, peak_entries);
    if (error_count == 0) begin
      $display("tb_eligibility_filtered_task_queue: clean");
    end else begin
      $display("tb_eligibility_filtered_task_queue: errors");
    end
    $finish;
  end

  // hard stop if the handshake hangs
  initial begin
    #5ms;
    $display("tb_eligibility_filtered_task_queue: errors");
    $finish;
  end

endmodule
